>>> rtl/core/sorted_list_insert_delete_core_defines.svh
// Assertion macros for the sorted list core.
// Depends on nothing; the asserting module supplies clk and rst_n.
`ifndef SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define SLID_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list core: same-cycle check failed");
// Next-cycle implication, checked outside reset.
`define SLID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list core: next-cycle check failed");
`else
`define SLID_ASSERT_IMPLY(label, ante, cons)
`define SLID_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/core/slid_pkg.sv
// Shared types and constants for the sorted list core.
// No dependencies; used by sorted_list_insert_delete_core.
package slid_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 2;
    localparam int RANK_W        = 4;
    localparam int ENTRY_COUNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_SCAN,
        ST_INS_HEAD,
        ST_DEL_SCAN,
        ST_RD_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] value;
        logic [RANK_W-1:0]        rank;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] read_value;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } rsp_t;

endpackage

>>> rtl/core/slid_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module slid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/sorted_list_insert_delete_core.sv
// Sorted list core: ascending list of signed 32-bit values kept in one RAM.
// Uses slid_pkg, slid_ram and the assertion macro header.
//
// Usage:
//   req carries {cmd, value, rank}: insert value, delete the first equal value,
//   or read the entry at an ascending rank. rsp carries {status, read_value,
//   entry_count}. Each channel transfers when valid is high and stall is low.
//   One command is worked at a time; req_stall is high while it is in flight.
//   Insert walks from the tail toward the head shifting entries up one slot,
//   delete walks from the head and shifts later entries down; the single RAM
//   port pair moves one entry per cycle.
//   To rsp_valid, a read passes through ST_RD_WAIT and ST_FINISH; insert and
//   delete pass their scan state, walking entries, plus ST_INS_HEAD for an
//   insert at rank 0, then ST_FINISH; a full insert, an empty list, a read
//   beyond the count or the unused code go straight to ST_FINISH. The next
//   request is taken after ST_FINISH registers the result and returns to idle.
//   The result register lets a new command start while rsp waits under stall;
//   the finished command then holds until the register frees up.
//   Reset empties the list at once (count goes to zero); RAM contents are not
//   cleared since only entries below the count are ever read.
`include "sorted_list_insert_delete_core_defines.svh"

module sorted_list_insert_delete_core #(
    parameter int DEPTH = slid_pkg::DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  slid_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output slid_pkg::rsp_t rsp
);

    import slid_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_reg, rsp_next;
    logic [AW-1:0]       cur_reg, cur_next;
    logic                found_reg, found_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [DATA_W-1:0]   rdval_reg, rdval_next;
    status_t             status_reg, status_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [DATA_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;

    logic                accept;
    logic                list_full;
    logic                list_empty;
    logic                rank_miss;
    logic                not_smaller;
    logic                match;
    logic                at_last;
    logic                hit;
    logic                rsp_free;

    slid_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_entries (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign req_stall   = (state_reg != ST_IDLE);
    assign accept      = req_valid && !req_stall;
    assign list_full   = (count_reg >= CW'(DEPTH));
    assign list_empty  = (count_reg == '0);
    assign rank_miss   = (32'(req.rank) >= 32'(count_reg)) || (32'(req.rank) >= 32'(DEPTH));
    assign not_smaller = ($signed(ram_rdata) >= $signed(val_reg));
    assign match       = (ram_rdata == val_reg);
    assign at_last     = (CW'(cur_reg) == (count_reg - CW'(1)));
    assign hit         = found_reg || match;
    assign rsp_free    = !rsp_valid_reg || !rsp_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (list_full || list_empty)
                            begin
                                state_next = ST_FINISH;
                            end
                            else
                            begin
                                state_next = ST_INS_SCAN;
                            end
                        end
                        CMD_DELETE:
                        begin
                            state_next = list_empty ? ST_FINISH : ST_DEL_SCAN;
                        end
                        CMD_READ:
                        begin
                            state_next = rank_miss ? ST_FINISH : ST_RD_WAIT;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_INS_SCAN:
            begin
                if (!not_smaller)
                begin
                    state_next = ST_FINISH;
                end
                else if (cur_reg == '0)
                begin
                    state_next = ST_INS_HEAD;
                end
            end
            ST_INS_HEAD:
            begin
                state_next = ST_FINISH;
            end
            ST_DEL_SCAN:
            begin
                if (at_last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_RD_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and RAM control
    always_comb
    begin
        count_next     = count_reg;
        cur_next       = cur_reg;
        found_next     = found_reg;
        val_next       = val_reg;
        rdval_next     = rdval_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = cur_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    val_next    = req.value;
                    found_next  = 1'b0;
                    rdval_next  = '0;
                    status_next = STATUS_OK;
                    unique case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (list_full)
                            begin
                                status_next = STATUS_FULL;
                            end
                            else if (list_empty)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = req.value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                // walk from the tail toward the head
                                ram_re    = 1'b1;
                                ram_raddr = AW'(count_reg - CW'(1));
                                cur_next  = AW'(count_reg - CW'(1));
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (list_empty)
                            begin
                                status_next = STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = '0;
                                cur_next  = '0;
                            end
                        end
                        CMD_READ:
                        begin
                            if (rank_miss)
                            begin
                                status_next = STATUS_RANGE;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = AW'(req.rank);
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_INS_SCAN:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg + AW'(1);
                if (not_smaller)
                begin
                    // shift this entry up one slot, fetch the one below
                    ram_wdata = ram_rdata;
                    if (cur_reg != '0)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = cur_reg - AW'(1);
                        cur_next  = cur_reg - AW'(1);
                    end
                end
                else
                begin
                    ram_wdata  = val_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            ST_INS_HEAD:
            begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = val_reg;
                count_next = count_reg + CW'(1);
            end
            ST_DEL_SCAN:
            begin
                // once the match is passed, move each entry down one slot
                if (found_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cur_reg - AW'(1);
                    ram_wdata = ram_rdata;
                end
                found_next = hit;
                if (at_last)
                begin
                    if (hit)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = cur_reg + AW'(1);
                    cur_next  = cur_reg + AW'(1);
                end
            end
            ST_RD_WAIT:
            begin
                rdval_next = ram_rdata;
            end
            ST_FINISH:
            begin
                if (rsp_free)
                begin
                    rsp_next.status      = status_reg;
                    rsp_next.read_value  = rdval_reg;
                    rsp_next.entry_count = ENTRY_COUNT_W'(count_reg);
                    rsp_valid_next       = 1'b1;
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        found_reg  <= found_next;
        val_reg    <= val_next;
        rdval_reg  <= rdval_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `SLID_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `SLID_ASSERT_IMPLY(a_del_cursor, state_reg == ST_DEL_SCAN, CW'(cur_reg) < count_reg)
    `SLID_ASSERT_NEXT(a_read_keeps_count, state_reg == ST_RD_WAIT, $stable(count_reg))
    `SLID_ASSERT_NEXT(a_finish_holds, (state_reg == ST_FINISH) && rsp_valid_reg && rsp_stall,
                      (state_reg == ST_FINISH) && $stable(rsp_reg))

endmodule
